// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// field widths, status and register codes, controller states
// ----------------------------------------------------------------------------
`default_nettype none
package pfa_pkg;

	// parameter defaults
	localparam int MAX_FRAMES_DEF = 64;
	localparam int ID_BITS_DEF    = 16;

	// fixed field widths
	localparam int FUNC_W   = 1;
	localparam int PID_W    = 16;
	localparam int SIZE_W   = 15;
	localparam int PS_W     = 9;
	localparam int STATUS_W = 3;
	localparam int PAGE_W   = 6;
	localparam int COUNT_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// dividend of a rounded-up division: size plus page minus one
	localparam int DIV_W = 16;
	localparam int DIV_CNT_W = 5;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_CREATE  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_DESTROY = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROC    = 2'd2;

	// register reset values
	localparam logic [PS_W-1:0]   PAGE_SIZE_RST = 9'd64;
	localparam logic [SIZE_W-1:0] MEM_SIZE_RST  = 15'd4096;
	localparam logic [SIZE_W-1:0] MAX_PROC_RST  = 15'd1024;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_NF,
		S_DIV_PG,
		S_SCAN,
		S_DECIDE,
		S_APPLY
	} pfa_state_t;

endpackage
`default_nettype wire

// ===== rtl/pfa_div.sv =====
// ----------------------------------------------------------------------------
// pfa_div: iterative unsigned divider
// restoring division, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module pfa_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pfa_pkg::DIV_W-1:0]  dividend,
	input  wire logic [pfa_pkg::PS_W-1:0]   divisor,
	output logic                            done,
	output logic [pfa_pkg::DIV_W-1:0]       quotient
);
	import pfa_pkg::*;

	logic [DIV_W-1:0]     quo_q;
	logic [PS_W-1:0]      rem_q;
	logic [PS_W-1:0]      dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [PS_W:0]        trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? PS_W'(trial - {1'b0, dvs_q}) : PS_W'(trial);
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/pfa_cell.sv =====
// ----------------------------------------------------------------------------
// pfa_cell: one entry of the frame and slot ring
// holds frame used/owner and slot valid/id, takes its neighbor's on shift
// ----------------------------------------------------------------------------
`default_nettype none
module pfa_cell #(
	parameter int OWN_W = 6,
	parameter int ID_W  = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift,
	input  wire logic             d_used,
	input  wire logic [OWN_W-1:0] d_owner,
	input  wire logic             d_valid,
	input  wire logic [ID_W-1:0]  d_pid,
	output logic                  q_used,
	output logic [OWN_W-1:0]      q_owner,
	output logic                  q_valid,
	output logic [ID_W-1:0]       q_pid
);
	logic             used_q;
	logic             valid_q;
	logic [OWN_W-1:0] owner_q;
	logic [ID_W-1:0]  pid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (shift) begin
			used_q  <= d_used;
			valid_q <= d_valid;
		end
	end

	// payload, meaningful only under its flag
	always_ff @(posedge clk) begin
		if (shift) begin
			owner_q <= d_owner;
			pid_q   <= d_pid;
		end
	end

	assign q_used  = used_q;
	assign q_owner = owner_q;
	assign q_valid = valid_q;
	assign q_pid   = pid_q;

endmodule
`default_nettype wire

// ===== rtl/page_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_top: paged memory frame allocator
// creates and destroys processes over a rotating ring of frame/slot cells
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+----------------------
//  request  | func, process_id, process_size            | start & !busy
//  result   | status, page_number, frame_number,        | strobe, one cycle
//           | page_count, last                          |
//  config   | cfg_index, cfg_data                       | cfg_valid & cfg_ready
//
//  busy covers a frame-count divider run, a page-count divider run for a create,
//  a scan turn of the ring, a decide state and, for a create that is carried
//  out or a destroy that finds its id, an apply turn of the ring
//  results of a create that takes frames come one per taken frame during the second ring turn
//  reset clears all valid/used flags at once; the receiver cannot stall
`default_nettype none
module page_frame_allocator_top #(
	parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
	parameter int ID_BITS    = pfa_pkg::ID_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request beat
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [pfa_pkg::FUNC_W-1:0]      func,
	input  wire logic [pfa_pkg::PID_W-1:0]       process_id,
	input  wire logic [pfa_pkg::SIZE_W-1:0]      process_size,
	// result beat
	output logic                                 strobe,
	output logic [pfa_pkg::STATUS_W-1:0]         status,
	output logic [pfa_pkg::PAGE_W-1:0]           page_number,
	output logic [pfa_pkg::PAGE_W-1:0]           frame_number,
	output logic [pfa_pkg::COUNT_W-1:0]          page_count,
	output logic                                 last,
	// config beat
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pfa_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAMES);
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	// configuration registers
	logic [PS_W-1:0]   page_size_q;
	logic [SIZE_W-1:0] memory_size_q;
	logic [SIZE_W-1:0] max_proc_q;

	// request registers
	logic [FUNC_W-1:0]  func_q;
	logic [ID_BITS-1:0] pid_q;
	logic [SIZE_W-1:0]  size_q;

	// controller
	pfa_state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic [CNT_W-1:0] nf_q;
	logic [DIV_W-1:0] pages_q;
	logic [CNT_W-1:0] nfree_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] freed_q;
	logic [IDX_W-1:0] fslot_q;
	logic [IDX_W-1:0] mslot_q;
	logic             ffound_q;
	logic             mfound_q;

	// result registers
	logic                strobe_q;
	logic [STATUS_W-1:0] status_q;
	logic [PAGE_W-1:0]   page_q;
	logic [PAGE_W-1:0]   frame_q;
	logic [COUNT_W-1:0]  count_q;
	logic                last_q;

	// ring
	logic             c_used  [MAX_FRAMES];
	logic             c_valid [MAX_FRAMES];
	logic [IDX_W-1:0] c_owner [MAX_FRAMES];
	logic [ID_BITS-1:0] c_pid [MAX_FRAMES];
	logic             m_used;
	logic             m_valid;
	logic [IDX_W-1:0] m_owner;
	logic [ID_BITS-1:0] m_pid;
	logic             shift;

	// divider
	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [PS_W-1:0]  eff_page;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	// head cell decode
	logic             accept;
	logic             last_idx;
	logic             in_range;
	logic             take;
	logic             own_hit;
	logic             scan_init;
	logic             emit;
	logic [STATUS_W-1:0] e_status;
	logic [PAGE_W-1:0]   e_page;
	logic [PAGE_W-1:0]   e_frame;
	logic [COUNT_W-1:0]  e_count;
	logic                e_last;

	assign accept    = start && !busy;
	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign eff_page  = (page_size_q == '0) ? PS_W'(1) : page_size_q;
	assign last_idx  = cnt_q == IDX_W'(MAX_FRAMES - 1);
	assign in_range  = CNT_W'(cnt_q) < nf_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q   <= PAGE_SIZE_RST;
			memory_size_q <= MEM_SIZE_RST;
			max_proc_q    <= MAX_PROC_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAGE_SIZE:   page_size_q   <= PS_W'(cfg_data);
				CFG_MEMORY_SIZE: memory_size_q <= SIZE_W'(cfg_data);
				CFG_MAX_PROC:    max_proc_q    <= SIZE_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// frame count first, then page count for a create, both rounded up
	assign div_dividend = (state_q == S_IDLE)
		? DIV_W'(memory_size_q) + DIV_W'(eff_page) - DIV_W'(1)
		: DIV_W'(size_q) + DIV_W'(eff_page) - DIV_W'(1);

	pfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (eff_page),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ring of cells, cell 0 is the head, the modified head wraps to the tail
	for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
		logic             nu;
		logic             nv;
		logic [IDX_W-1:0] no;
		logic [ID_BITS-1:0] np;
		if (g == MAX_FRAMES - 1) begin : g_tail
			assign nu = m_used;
			assign nv = m_valid;
			assign no = m_owner;
			assign np = m_pid;
		end else begin : g_mid
			assign nu = c_used[g+1];
			assign nv = c_valid[g+1];
			assign no = c_owner[g+1];
			assign np = c_pid[g+1];
		end
		pfa_cell #(
			.OWN_W (IDX_W),
			.ID_W  (ID_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.d_used  (nu),
			.d_owner (no),
			.d_valid (nv),
			.d_pid   (np),
			.q_used  (c_used[g]),
			.q_owner (c_owner[g]),
			.q_valid (c_valid[g]),
			.q_pid   (c_pid[g])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept) state_d = S_DIV_NF;
			S_DIV_NF: if (div_done) state_d = (func_q == FUNC_DESTROY) ? S_SCAN : S_DIV_PG;
			S_DIV_PG: if (div_done) state_d = S_SCAN;
			S_SCAN:   if (last_idx) state_d = S_DECIDE;
			S_DECIDE: begin
				if (func_q == FUNC_DESTROY) begin
					state_d = mfound_q ? S_APPLY : S_IDLE;
				end else if (size_q > max_proc_q || DIV_W'(nfree_q) < pages_q || !ffound_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_APPLY;
				end
			end
			S_APPLY:  if (last_idx) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs: divider starts, head modification, result beats
	always_comb begin
		div_start = 1'b0;
		shift     = 1'b0;
		scan_init = 1'b0;
		m_used    = c_used[0];
		m_valid   = c_valid[0];
		m_owner   = c_owner[0];
		m_pid     = c_pid[0];
		take      = 1'b0;
		own_hit   = c_used[0] && c_owner[0] == mslot_q;
		emit      = 1'b0;
		e_status  = ST_OK;
		e_page    = '0;
		e_frame   = '0;
		e_count   = '0;
		e_last    = 1'b1;
		case (state_q)
			S_IDLE: div_start = accept;
			S_DIV_NF: begin
				div_start = div_done && func_q == FUNC_CREATE;
				scan_init = div_done && func_q == FUNC_DESTROY;
			end
			S_DIV_PG: scan_init = div_done;
			S_SCAN: shift = 1'b1;
			S_DECIDE: begin
				if (func_q == FUNC_DESTROY) begin
					emit     = !mfound_q;
					e_status = ST_NOT_FOUND;
				end else if (size_q > max_proc_q) begin
					emit     = 1'b1;
					e_status = ST_TOO_LARGE;
				end else if (DIV_W'(nfree_q) < pages_q) begin
					emit     = 1'b1;
					e_status = ST_NO_FRAMES;
				end else if (!ffound_q) begin
					emit     = 1'b1;
					e_status = ST_NO_SLOT;
				end else begin
					// zero-page create: answered now, slot is taken in the turn
					emit = pages_q == '0;
				end
			end
			S_APPLY: begin
				shift = 1'b1;
				if (func_q == FUNC_DESTROY) begin
					if (own_hit) m_used = 1'b0;
					if (cnt_q == mslot_q) m_valid = 1'b0;
					emit    = last_idx;
					e_count = COUNT_W'(freed_q + CNT_W'(own_hit));
				end else begin
					take = in_range && !c_used[0] && DIV_W'(k_q) < pages_q;
					if (cnt_q == fslot_q) begin
						m_valid = 1'b1;
						m_pid   = pid_q;
					end
					if (take) begin
						m_used  = 1'b1;
						m_owner = fslot_q;
					end
					emit    = take;
					e_page  = PAGE_W'(k_q);
					e_frame = PAGE_W'(cnt_q);
					e_count = COUNT_W'(pages_q);
					e_last  = DIV_W'(k_q) + DIV_W'(1) == pages_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	// request, counters and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			pid_q  <= ID_BITS'(process_id);
			size_q <= process_size;
		end
		if (state_q == S_DIV_NF && div_done) begin
			nf_q <= (div_quo > DIV_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : CNT_W'(div_quo);
		end
		if (state_q == S_DIV_PG && div_done) pages_q <= div_quo;
		if (scan_init) begin
			cnt_q    <= '0;
			nfree_q  <= '0;
			ffound_q <= 1'b0;
			mfound_q <= 1'b0;
			fslot_q  <= '0;
			mslot_q  <= '0;
		end
		if (state_q == S_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
			if (in_range && !c_used[0]) nfree_q <= nfree_q + 1'b1;
			if (!ffound_q && in_range && !c_valid[0]) begin
				ffound_q <= 1'b1;
				fslot_q  <= cnt_q;
			end
			if (!mfound_q && c_valid[0] && c_pid[0] == pid_q) begin
				mfound_q <= 1'b1;
				mslot_q  <= cnt_q;
			end
		end
		if (state_q == S_DECIDE) begin
			cnt_q   <= '0;
			k_q     <= '0;
			freed_q <= '0;
		end
		if (state_q == S_APPLY) begin
			cnt_q <= cnt_q + 1'b1;
			if (take) k_q <= k_q + 1'b1;
			if (func_q == FUNC_DESTROY && own_hit) freed_q <= freed_q + 1'b1;
		end
		if (emit) begin
			status_q <= e_status;
			page_q   <= e_page;
			frame_q  <= e_frame;
			count_q  <= e_count;
			last_q   <= e_last;
		end
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign page_number  = page_q;
	assign frame_number = frame_q;
	assign page_count   = count_q;
	assign last         = last_q;

`ifndef SYNTH
	// a result beat only follows work on a request
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q != S_IDLE))
		else $error("result beat without a request in flight");

	// allocation never hands out more pages than requested
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && func_q == FUNC_CREATE) |-> DIV_W'(k_q) <= pages_q)
		else $error("more pages allocated than requested");

	// a create turn ends with exactly the requested pages taken
	a_k_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && func_q == FUNC_CREATE && last_idx)
		|=> DIV_W'(k_q) == pages_q)
		else $error("create turn ended short of its page count");

	// a ring turn always starts at the head
	a_turn_start: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_DECIDE && state_q == S_APPLY) |-> cnt_q == '0)
		else $error("ring turn not aligned to head");
`endif

endmodule
`default_nettype wire

// ===== bench/pfa_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfa_checker: frame allocation predictor and result checker
// watches the request, config and result channels of the allocator, keeps
// its own copy of the frame and slot tables and checks every result beat
// ----------------------------------------------------------------------------
module pfa_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic                           busy,
	input  wire logic [pfa_pkg::FUNC_W-1:0]     func,
	input  wire logic [pfa_pkg::PID_W-1:0]      process_id,
	input  wire logic [pfa_pkg::SIZE_W-1:0]     process_size,
	input  wire logic                           strobe,
	input  wire logic [pfa_pkg::STATUS_W-1:0]   status,
	input  wire logic [pfa_pkg::PAGE_W-1:0]     page_number,
	input  wire logic [pfa_pkg::PAGE_W-1:0]     frame_number,
	input  wire logic [pfa_pkg::COUNT_W-1:0]    page_count,
	input  wire logic                           last,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  fail_count,
	output int                                  beats_pending
);
	import pfa_pkg::*;

	localparam int NFR = MAX_FRAMES_DEF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   page;
		logic [PAGE_W-1:0]   frame;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} alloc_beat_t;

	alloc_beat_t      expected_beats[$];
	logic [PS_W-1:0]  page_size_q;
	logic [SIZE_W-1:0] mem_size_q;
	logic [SIZE_W-1:0] max_proc_q;
	bit               frame_used[NFR];
	logic [5:0]       frame_owner[NFR];
	bit               slot_valid[NFR];
	logic [PID_W-1:0] slot_pid[NFR];

	function automatic alloc_beat_t mk(input logic [STATUS_W-1:0] st, input int pg,
			input int fr, input int cnt, input bit lst);
		alloc_beat_t b;
		b.status = st;
		b.page   = pg[PAGE_W-1:0];
		b.frame  = fr[PAGE_W-1:0];
		b.count  = cnt[COUNT_W-1:0];
		b.last   = lst;
		return b;
	endfunction

	task automatic allocate_or_free(input logic [FUNC_W-1:0] f, input logic [PID_W-1:0] pid,
			input logic [SIZE_W-1:0] size);
		int pg_bytes;
		int nframes;
		int pages;
		int nfree;
		int slot;
		int freed;
		int k;
		pg_bytes = (page_size_q == 0) ? 1 : int'(page_size_q);
		nframes  = (int'(mem_size_q) + pg_bytes - 1) / pg_bytes;
		if (nframes > NFR) nframes = NFR;
		if (f == FUNC_DESTROY) begin
			slot = -1;
			for (int i = 0; i < NFR; i++)
				if (slot < 0 && slot_valid[i] && slot_pid[i] == pid) slot = i;
			if (slot < 0) begin
				expected_beats.push_back(mk(ST_NOT_FOUND, 0, 0, 0, 1));
				return;
			end
			slot_valid[slot] = 0;
			freed = 0;
			for (int i = 0; i < NFR; i++)
				if (frame_used[i] && frame_owner[i] == slot[5:0]) begin
					frame_used[i] = 0;
					freed++;
				end
			expected_beats.push_back(mk(ST_OK, 0, 0, freed, 1));
			return;
		end
		if (size > max_proc_q) begin
			expected_beats.push_back(mk(ST_TOO_LARGE, 0, 0, 0, 1));
			return;
		end
		pages = (int'(size) + pg_bytes - 1) / pg_bytes;
		nfree = 0;
		for (int i = 0; i < nframes; i++)
			if (!frame_used[i]) nfree++;
		if (nfree < pages) begin
			expected_beats.push_back(mk(ST_NO_FRAMES, 0, 0, 0, 1));
			return;
		end
		slot = -1;
		for (int i = 0; i < nframes; i++)
			if (slot < 0 && !slot_valid[i]) slot = i;
		if (slot < 0) begin
			expected_beats.push_back(mk(ST_NO_SLOT, 0, 0, 0, 1));
			return;
		end
		slot_valid[slot] = 1;
		slot_pid[slot]   = pid;
		if (pages == 0) begin
			expected_beats.push_back(mk(ST_OK, 0, 0, 0, 1));
			return;
		end
		k = 0;
		for (int i = 0; i < nframes; i++)
			if (k < pages && !frame_used[i]) begin
				frame_used[i]  = 1;
				frame_owner[i] = slot[5:0];
				expected_beats.push_back(mk(ST_OK, k, i, pages, k + 1 == pages));
				k++;
			end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_beat_t e;
		if (!arst_n) begin
			page_size_q = PAGE_SIZE_RST;
			mem_size_q  = MEM_SIZE_RST;
			max_proc_q  = MAX_PROC_RST;
			for (int i = 0; i < NFR; i++) begin
				frame_used[i] = 0;
				slot_valid[i] = 0;
			end
			expected_beats.delete();
			fail_count    = 0;
			beats_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PAGE_SIZE:   page_size_q = cfg_data[PS_W-1:0];
					CFG_MEMORY_SIZE: mem_size_q  = cfg_data;
					CFG_MAX_PROC:    max_proc_q  = cfg_data;
					default: ;
				endcase
			end
			if (strobe) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat: status %0d", status);
					fail_count++;
				end else begin
					e = expected_beats.pop_front();
					check_field("status", e.status, status);
					check_field("page_number", e.page, page_number);
					check_field("frame_number", e.frame, frame_number);
					check_field("page_count", e.count, page_count);
					check_field("last", e.last, last);
				end
			end
			if (start && !busy) allocate_or_free(func, process_id, process_size);
			beats_pending = expected_beats.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the page frame allocator
// directed creates and destroys hit the size limits, duplicate ids, missing
// ids, full memory and a full slot table; then random create/destroy traffic
// under changing page and memory settings, checked by pfa_checker
// ----------------------------------------------------------------------------
module tb_top;
	import pfa_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [FUNC_W-1:0]     func;
	logic [PID_W-1:0]      process_id;
	logic [SIZE_W-1:0]     process_size;
	logic                  strobe;
	logic [STATUS_W-1:0]   status;
	logic [PAGE_W-1:0]     page_number;
	logic [PAGE_W-1:0]     frame_number;
	logic [COUNT_W-1:0]    page_count;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    beats_pending;

	// settings used to shape the random sizes and sender gaps
	int cur_page;
	int cur_max;
	int send_idle_pct;
	// ids created so far, used to pick destroy targets
	logic [PID_W-1:0] live_ids[$];
	int cycle_cnt;

	localparam int CYCLE_LIMIT = 600000;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	page_frame_allocator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.func(func), .process_id(process_id), .process_size(process_size),
		.strobe(strobe), .status(status), .page_number(page_number),
		.frame_number(frame_number), .page_count(page_count), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pfa_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.func(func), .process_id(process_id), .process_size(process_size),
		.strobe(strobe), .status(status), .page_number(page_number),
		.frame_number(frame_number), .page_count(page_count), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .beats_pending(beats_pending)
	);

	// watchdog: a hung block ends the run here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// one request beat; busy only moves at the rising edge, so it is
	// looked at on the falling edge and the beat lands on the next edge
	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [PID_W-1:0] pid,
			input logic [SIZE_W-1:0] size);
		start        <= 1'b1;
		func         <= f;
		process_id   <= pid;
		process_size <= size;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		if (f == FUNC_CREATE) begin
			live_ids.push_back(pid);
			if (live_ids.size() > 40) void'(live_ids.pop_front());
		end
		// random sender gap, start dropped only when a gap follows
		if ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every expected beat came back and the block is idle
	task automatic drain;
		start <= 1'b0;
		forever begin
			@(negedge clk);
			if (beats_pending == 0 && !busy) break;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic set_geometry(input int pg, input int mem, input int maxp);
		drain();
		write_reg(CFG_PAGE_SIZE, pg);
		write_reg(CFG_MEMORY_SIZE, mem);
		write_reg(CFG_MAX_PROC, maxp);
		cur_page = (pg % 512 == 0) ? 1 : pg % 512;
		cur_max  = maxp;
	endtask

	// mostly sizes that fit, some zero, some just over the limit, some wild
	function automatic logic [SIZE_W-1:0] pick_size;
		int r;
		int hi;
		r  = $urandom_range(0, 19);
		hi = (cur_max < cur_page * 8) ? cur_max : cur_page * 8;
		if (hi < 1) hi = 1;
		if (r == 0) return '0;
		if (r == 1) return SIZE_W'($urandom);
		if (r == 2) return SIZE_W'(cur_max + $urandom_range(1, 40));
		if (r == 3) return SIZE_W'(cur_max);
		return SIZE_W'($urandom_range(1, hi));
	endfunction

	function automatic logic [PID_W-1:0] pick_id;
		case ($urandom_range(0, 3))
			0:       return PID_W'($urandom);
			1:       return $urandom_range(0, 1) ? '1 : '0;
			default: return PID_W'($urandom_range(0, 9));
		endcase
	endfunction

	task automatic random_traffic(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 55)
				send_request(FUNC_CREATE, pick_id(), pick_size());
			else if (live_ids.size() > 0 && $urandom_range(0, 9) < 8)
				send_request(FUNC_DESTROY,
					live_ids[$urandom_range(0, live_ids.size() - 1)], SIZE_W'($urandom));
			else
				send_request(FUNC_DESTROY, pick_id(), SIZE_W'($urandom));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		func          = FUNC_CREATE;
		process_id    = '0;
		process_size  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_PAGE_SIZE;
		cfg_data      = '0;
		cycle_cnt     = 0;
		cur_page      = PAGE_SIZE_RST;
		cur_max       = MAX_PROC_RST;
		send_idle_pct = 16;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset geometry, 64 frames of 64 bytes
		send_request(FUNC_CREATE, 16'h0001, 15'd0);       // zero-size create
		send_request(FUNC_CREATE, 16'h0002, 15'd1024);    // exactly the limit
		send_request(FUNC_CREATE, 16'h0003, 15'd1025);    // just too large
		send_request(FUNC_CREATE, 16'h0003, 15'h7fff);    // far too large
		send_request(FUNC_CREATE, 16'hffff, 15'd1);
		send_request(FUNC_CREATE, 16'h0005, 15'd65);      // duplicate ids
		send_request(FUNC_CREATE, 16'h0005, 15'd64);
		send_request(FUNC_DESTROY, 16'h0005, 15'h7fff);   // lowest match first
		send_request(FUNC_DESTROY, 16'h0005, 15'd0);
		send_request(FUNC_DESTROY, 16'h0005, 15'd0);      // id now gone
		send_request(FUNC_CREATE, 16'h0006, 15'd1024);    // fill memory
		send_request(FUNC_CREATE, 16'h0007, 15'd1024);
		send_request(FUNC_CREATE, 16'h0008, 15'd1024);
		send_request(FUNC_CREATE, 16'h0009, 15'd1024);    // not enough frames
		send_request(FUNC_DESTROY, 16'h0002, 15'd0);
		send_request(FUNC_DESTROY, 16'h0000, 15'd0);
		// one frame only: slot table of one entry, shrunk memory
		set_geometry(1, 1, 1);
		send_request(FUNC_CREATE, 16'h000a, 15'd0);       // no slot below count
		send_request(FUNC_CREATE, 16'h000b, 15'd1);
		send_request(FUNC_DESTROY, 16'h0006, 15'd0);      // frames beyond count freed
		send_request(FUNC_DESTROY, 16'h0001, 15'd0);
		send_request(FUNC_CREATE, 16'h000c, 15'd1);
		send_request(FUNC_CREATE, 16'h000d, 15'd0);
		// page size zero acts as one byte
		set_geometry(0, 64, 64);
		send_request(FUNC_CREATE, 16'h000e, 15'd64);
		send_request(FUNC_CREATE, 16'h000f, 15'd1);

		// random phases: sender idles 16%, then 50%, then never
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 50 : 0;
			set_geometry(64, 4096, 1024);
			random_traffic(30);
			set_geometry(256, 16384, 16384);
			random_traffic(20);
			set_geometry(16, 512, 300);
			random_traffic(25);
			set_geometry(511, 32767, 32767);
			random_traffic(15);
			set_geometry(100, 1000, 3000);
			random_traffic(15);
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
